/* rtl/core/swhsr_pkg.sv */
// ============================================================================
// swhsr_pkg
// Shared types and constants for the single-wire humidity sensor reader.
// ============================================================================
package swhsr_pkg;

    // Number of level runs after which a read ends.
    localparam logic [6:0] RUN_BUDGET = 7'd85;
    // Data bits kept per read: four data bytes and the sum byte.
    localparam logic [5:0] MAX_BITS   = 6'd40;
    localparam logic [7:0] RUN_MAX    = 8'hFF;

    localparam logic [15:0] START_LOW_RESET = 16'd18000;
    localparam logic [7:0]  RELEASE_RESET   = 8'd40;
    localparam logic [7:0]  THRESHOLD_RESET = 8'd16;
    localparam logic [7:0]  TIMEOUT_RESET   = 8'd255;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_START,
        PH_RELEASE,
        PH_MEASURE
    } phase_t;

    typedef enum logic [1:0] {
        REG_START_LOW,
        REG_RELEASE,
        REG_THRESHOLD,
        REG_TIMEOUT
    } reg_idx_t;

    typedef struct packed {
        logic line_level;
        logic start_request;
    } swhsr_in_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       checksum_ok;
        logic       timed_out;
        logic [7:0] humidity_whole;
        logic [7:0] humidity_tenths;
        logic [7:0] temp_whole;
        logic [7:0] temp_tenths;
    } swhsr_out_t;

    typedef struct packed {
        logic [15:0] start_low_ticks;
        logic [7:0]  release_ticks;
        logic [7:0]  bit_threshold;
        logic [7:0]  timeout_ticks;
    } swhsr_cfg_t;

endpackage

/* rtl/core/single_wire_humidity_sensor_reader.sv */
// ============================================================================
// single_wire_humidity_sensor_reader
// Top level: APB register file, tick queue and decode engine.
// ============================================================================
// Each input beat is one microsecond tick of the sensor line; each tick gives
// exactly one result beat. The block sustains one tick per clock cycle when
// neither side stalls: a two-entry input queue feeds the decode engine, which
// updates its state and loads the output register in the same cycle. An
// accepted beat is first written into the queue, then popped by the engine
// into the output register, where it is held until the output side takes it.
// A start request while idle drives the line low for start_low_ticks ticks,
// releases it for release_ticks ticks, then decodes 40 data bits from the
// high-run lengths; done_res marks the tick the read ends, with checksum_ok
// and timed_out valid on that beat. Registers sit at byte addresses 0, 4, 8
// and 12 and should be written only while no read is in progress.
// ============================================================================
module single_wire_humidity_sensor_reader
    import swhsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  swhsr_in_t   in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output swhsr_out_t  out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    swhsr_cfg_t cfg_reg;
    logic       q_valid;
    swhsr_in_t  q_data;
    logic       q_pop;
    logic       wr_en;
    reg_idx_t   reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_low_ticks <= START_LOW_RESET;
            cfg_reg.release_ticks   <= RELEASE_RESET;
            cfg_reg.bit_threshold   <= THRESHOLD_RESET;
            cfg_reg.timeout_ticks   <= TIMEOUT_RESET;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                REG_START_LOW: cfg_reg.start_low_ticks <= pwdata[15:0];
                REG_RELEASE:   cfg_reg.release_ticks   <= pwdata[7:0];
                REG_THRESHOLD: cfg_reg.bit_threshold   <= pwdata[7:0];
                REG_TIMEOUT:   cfg_reg.timeout_ticks   <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_START_LOW: prdata = {16'd0, cfg_reg.start_low_ticks};
            REG_RELEASE:   prdata = {24'd0, cfg_reg.release_ticks};
            REG_THRESHOLD: prdata = {24'd0, cfg_reg.bit_threshold};
            REG_TIMEOUT:   prdata = {24'd0, cfg_reg.timeout_ticks};
            default:       prdata = 32'd0;
        endcase
    end

    swhsr_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop)
    );

    swhsr_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

/* rtl/core/swhsr_front.sv */
// ============================================================================
// swhsr_front
// Input side: accepts tick beats and holds them in a two-entry queue for the
// decode engine.
// ============================================================================
module swhsr_front
    import swhsr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  swhsr_in_t in_data,
    output logic      q_valid,
    output swhsr_in_t q_data,
    input  logic      q_pop
);

    swhsr_in_t  mem [QUEUE_DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;

    assign in_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign push     = in_valid && in_ready;
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push  ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != 2'd0)
        else $error("pop from empty queue");
    a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> count_reg == $past(count_reg) + 2'd1)
        else $error("queue count did not advance on push");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd0 || count_reg == 2'd2) |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers out of step with count");
`endif

endmodule

/* rtl/core/swhsr_engine.sv */
// ============================================================================
// swhsr_engine
// Decode side: runs the start pulse, measures level runs, shifts in data
// bits and presents one result beat per tick through an output register.
// ============================================================================
module swhsr_engine
    import swhsr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  swhsr_cfg_t cfg,
    input  logic       q_valid,
    input  swhsr_in_t  q_data,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_ready,
    output swhsr_out_t out_data
);

    phase_t      phase_reg, phase_next;
    logic [15:0] timer_reg, timer_next;
    logic [7:0]  run_len_reg, run_len_next;
    logic        prev_reg, prev_next;
    logic [6:0]  run_idx_reg, run_idx_next;
    logic [5:0]  bit_cnt_reg, bit_cnt_next;
    logic [39:0] data_reg, data_next;
    logic        out_valid_reg;
    swhsr_out_t  out_data_reg, result;

    // Advance when the output slot is free or is being emptied this cycle.
    assign q_pop     = q_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        logic       done;
        logic       tmo;
        logic       one;
        logic [2:0] k;
        logic [7:0] sum;

        phase_next   = phase_reg;
        timer_next   = timer_reg;
        run_len_next = run_len_reg;
        prev_next    = prev_reg;
        run_idx_next = run_idx_reg;
        bit_cnt_next = bit_cnt_reg;
        data_next    = data_reg;
        done         = 1'b0;
        tmo          = 1'b0;
        one          = 1'b0;
        k            = 3'd0;
        sum          = 8'd0;
        result       = '0;

        if (phase_reg == PH_IDLE && q_data.start_request)
        begin
            phase_next   = PH_START;
            timer_next   = 16'd0;
            run_len_next = 8'd0;
            prev_next    = 1'b1;
            run_idx_next = 7'd0;
            bit_cnt_next = 6'd0;
            data_next    = 40'd0;
        end

        case (phase_next)
            PH_START:
            begin
                result.drive_low = 1'b1;
                timer_next = timer_next + 16'd1;
                if (timer_next >= cfg.start_low_ticks)
                begin
                    timer_next = 16'd0;
                    phase_next = (cfg.release_ticks == 8'd0) ? PH_MEASURE : PH_RELEASE;
                end
            end
            PH_RELEASE:
            begin
                timer_next = timer_next + 16'd1;
                if (timer_next >= {8'd0, cfg.release_ticks})
                begin
                    timer_next = 16'd0;
                    phase_next = PH_MEASURE;
                end
            end
            PH_MEASURE:
            begin
                if (q_data.line_level == prev_next)
                begin
                    if (run_len_next != RUN_MAX)
                    begin
                        run_len_next = run_len_next + 8'd1;
                    end
                    if (run_len_next >= cfg.timeout_ticks)
                    begin
                        done = 1'b1;
                        tmo  = 1'b1;
                    end
                end
                else
                begin
                    // Close the run: even high runs from the fifth on carry a bit.
                    if (run_idx_next >= 7'd4 && !run_idx_next[0] && bit_cnt_next < MAX_BITS)
                    begin
                        one = (run_len_next > cfg.bit_threshold);
                        k   = bit_cnt_next[5:3];
                        for (int j = 0; j < 5; j++)
                        begin
                            if (k == 3'(j))
                            begin
                                data_next[39-8*j -: 8] = {data_next[38-8*j -: 7], one};
                            end
                        end
                        bit_cnt_next = bit_cnt_next + 6'd1;
                    end
                    prev_next    = q_data.line_level;
                    run_idx_next = run_idx_next + 7'd1;
                    run_len_next = 8'd1;
                    if (run_idx_next >= RUN_BUDGET)
                    begin
                        done = 1'b1;
                    end
                    else if (cfg.timeout_ticks <= 8'd1)
                    begin
                        done = 1'b1;
                        tmo  = 1'b1;
                    end
                end
                if (done)
                begin
                    sum = data_next[39:32] + data_next[31:24] + data_next[23:16]
                        + data_next[15:8];
                    result.checksum_ok = (bit_cnt_next >= MAX_BITS) && (data_next[7:0] == sum);
                    phase_next = PH_IDLE;
                end
            end
            default:
            begin
            end
        endcase

        result.busy_res        = (phase_next != PH_IDLE);
        result.done_res        = done;
        result.timed_out       = tmo;
        result.humidity_whole  = data_next[39:32];
        result.humidity_tenths = data_next[31:24];
        result.temp_whole      = data_next[23:16];
        result.temp_tenths     = data_next[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= 16'd0;
            run_len_reg   <= 8'd0;
            prev_reg      <= 1'b1;
            run_idx_reg   <= 7'd0;
            bit_cnt_reg   <= 6'd0;
            data_reg      <= 40'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                phase_reg   <= phase_next;
                timer_reg   <= timer_next;
                run_len_reg <= run_len_next;
                prev_reg    <= prev_next;
                run_idx_reg <= run_idx_next;
                bit_cnt_reg <= bit_cnt_next;
                data_reg    <= data_next;
            end
            if (q_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            out_data_reg <= result;
        end
    end

`ifndef SYNTHESIS
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.done_res) |-> !out_data_reg.busy_res)
        else $error("done beat reports busy");
    a_flags_need_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_data_reg.checksum_ok || out_data_reg.timed_out))
        |-> out_data_reg.done_res)
        else $error("status flag outside a done beat");
    a_bit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bit_cnt_reg <= MAX_BITS)
        else $error("bit count past 40");
    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && result.done_res) |=> phase_reg == PH_IDLE)
        else $error("engine not idle after done");
`endif

endmodule
